// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Invariant
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`endif

// ===== sv/u2u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u2u8_pkg
// Types, constants and byte encoding helpers for the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

  localparam int unsigned RESULTS_MAX = 6;

  localparam logic [10:0] MAX_CAPACITY = 11'd1024;
  localparam logic [10:0] COUNT_LIMIT  = 11'd2047;
  localparam logic [10:0] CAPACITY_RST = 11'd1024;

  localparam logic [15:0] UNIT_1B_MAX = 16'h007f;
  localparam logic [15:0] UNIT_2B_MAX = 16'h07ff;
  localparam logic [15:0] SURR_MASK   = 16'hfc00;
  localparam logic [15:0] SURR_HIGH   = 16'hd800;
  localparam logic [15:0] SURR_LOW    = 16'hdc00;
  localparam logic [10:0] PLANE_OFS   = 11'h040;

  localparam logic [7:0] LEAD_2B = 8'hc0;
  localparam logic [7:0] LEAD_3B = 8'he0;
  localparam logic [7:0] LEAD_4B = 8'hf0;
  localparam logic [7:0] CONT    = 8'h80;

  // register indexes on the APB port
  localparam logic REG_CAPACITY   = 1'b0;
  localparam logic REG_COUNT_ONLY = 1'b1;

  typedef struct packed {
    logic [9:0]  held_high;
    logic        have_held;
    logic [10:0] bytes_written;
    logic        stopped;
  } str_state_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_terminator;
    logic        run_last;
    logic [10:0] byte_length;
    logic        truncated;
  } res_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [2:0][7:0] b;
  } enc_t;

  typedef struct packed {
    logic        emit;
    logic [10:0] bw;
    logic        st;
  } seq_t;

  function automatic enc_t enc_unit(input logic [15:0] u);
    enc_t e;
    e.n = 3'd3;
    e.b = '0;
    if (u <= UNIT_1B_MAX) begin
      e.n    = 3'd1;
      e.b[0] = u[7:0];
    end else if (u <= UNIT_2B_MAX) begin
      e.n    = 3'd2;
      e.b[0] = LEAD_2B | {3'b000, u[10:6]};
      e.b[1] = CONT | {2'b00, u[5:0]};
    end else begin
      e.b[0] = LEAD_3B | {4'b0000, u[15:12]};
      e.b[1] = CONT | {2'b00, u[11:6]};
      e.b[2] = CONT | {2'b00, u[5:0]};
    end
    return e;
  endfunction

endpackage

// ===== sv/u2u8_plan.sv =====
// ----------------------------------------------------------------------------
// u2u8_plan
// Works out, for one code unit, the result list and the next string state.
// ----------------------------------------------------------------------------
module u2u8_plan import u2u8_pkg::*; (
  input  logic [15:0]                   unit,
  input  str_state_t                    state,
  input  logic [10:0]                   capacity,
  input  logic                          count_only,
  output str_state_t                    state_next,
  output res_t [RESULTS_MAX-1:0]        res,
  output logic [2:0]                    res_cnt
);

  logic [10:0]     lim;
  logic            is_low;
  logic            is_high;
  enc_t            enc_a;
  enc_t            enc_b;
  seq_t            sqa;
  seq_t            sqb;
  logic [10:0]     bw1;
  logic            st1;
  logic [2:0]      a_n;
  logic [2:0]      b_n;
  logic [3:0][7:0] a_b;
  logic [2:0][7:0] b_b;
  logic            term;
  logic [10:0]     z;
  logic [2:0]      j;

  function automatic seq_t emit_seq(input logic [10:0] bw, input logic st,
                                    input logic [2:0] n, input logic [10:0] lm,
                                    input logic co);
    seq_t        r;
    logic [11:0] sum;
    r.emit = 1'b0;
    r.bw   = bw;
    r.st   = st;
    sum    = {1'b0, bw} + {9'd0, n};
    if (!st) begin
      if (co) begin
        r.bw = (sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : sum[10:0];
      end else if (sum + 12'd1 > {1'b0, lm}) begin
        r.st = 1'b1;
      end else begin
        r.emit = 1'b1;
        r.bw   = sum[10:0];
      end
    end
    return r;
  endfunction

  assign lim     = (capacity > MAX_CAPACITY) ? MAX_CAPACITY : capacity;
  assign is_low  = (unit & SURR_MASK) == SURR_LOW;
  assign is_high = (unit & SURR_MASK) == SURR_HIGH;
  assign enc_a   = enc_unit(SURR_HIGH | {6'd0, state.held_high});
  assign enc_b   = enc_unit(unit);
  assign z       = {1'b0, state.held_high} + PLANE_OFS;

  always_comb begin
    state_next = state;
    sqa        = '0;
    sqb        = '0;
    bw1        = state.bytes_written;
    st1        = state.stopped;
    a_n        = 3'd0;
    b_n        = 3'd0;
    a_b        = '0;
    b_b        = enc_b.b;
    term       = 1'b0;
    if (state.have_held && is_low) begin
      // surrogate pair: four bytes, lead byte keeps three bits of the plane
      sqa    = emit_seq(state.bytes_written, state.stopped, 3'd4, lim, count_only);
      a_n    = sqa.emit ? 3'd4 : 3'd0;
      a_b[0] = LEAD_4B | {5'd0, z[10:8]};
      a_b[1] = CONT | {2'b00, z[7:2]};
      a_b[2] = CONT | {2'b00, z[1:0], unit[9:6]};
      a_b[3] = CONT | {2'b00, unit[5:0]};
      state_next = '{held_high: '0, have_held: 1'b0, bytes_written: sqa.bw,
                     stopped: sqa.st};
    end else begin
      if (state.have_held) begin
        // lone high surrogate flushed as three bytes
        sqa = emit_seq(state.bytes_written, state.stopped, enc_a.n, lim, count_only);
        a_n = sqa.emit ? enc_a.n : 3'd0;
        a_b = {8'd0, enc_a.b};
        bw1 = sqa.bw;
        st1 = sqa.st;
      end
      if (unit == '0) begin
        term       = 1'b1;
        b_n        = 3'd1;
        state_next = '0;
      end else if (!st1 && is_high) begin
        state_next = '{held_high: unit[9:0], have_held: 1'b1, bytes_written: bw1,
                       stopped: st1};
      end else if (!st1) begin
        sqb        = emit_seq(bw1, st1, enc_b.n, lim, count_only);
        b_n        = sqb.emit ? enc_b.n : 3'd0;
        state_next = '{held_high: '0, have_held: 1'b0, bytes_written: sqb.bw,
                       stopped: sqb.st};
      end else begin
        state_next = '{held_high: '0, have_held: 1'b0, bytes_written: bw1,
                       stopped: st1};
      end
    end
  end

  assign res_cnt = a_n + b_n;

  always_comb begin
    j = '0;
    for (int i = 0; i < RESULTS_MAX; i++) begin
      res[i] = '0;
      j      = 3'(i) - a_n;
      if (3'(i) < a_n) begin
        res[i].out_byte = a_b[2'(i)];
      end else if (term) begin
        res[i].is_terminator = 1'b1;
        res[i].byte_length   = bw1;
        res[i].truncated     = st1;
      end else if (j < 3'd3) begin
        res[i].out_byte = b_b[j[1:0]];
      end
      res[i].run_last = (3'(i) == res_cnt - 3'd1);
    end
  end

endmodule

// ===== sv/u2u8_outbuf.sv =====
// ----------------------------------------------------------------------------
// u2u8_outbuf
// Result buffer: holds one unit's results and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module u2u8_outbuf import u2u8_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  res_t [RESULTS_MAX-1:0] load_res,
  input  logic [2:0]             load_cnt,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   is_terminator,
  output logic                   run_last,
  output logic [10:0]            byte_length,
  output logic                   truncated
);

  res_t [RESULTS_MAX-1:0] ents;
  logic [2:0]             rem;
  logic [2:0]             idx;
  res_t                   cur;

  assign out_valid = rem != '0;
  assign free      = (rem == '0) || (rem == 3'd1 && out_ready);
  assign cur       = ents[idx];

  assign out_byte      = cur.out_byte;
  assign is_terminator = cur.is_terminator;
  assign run_last      = cur.run_last;
  assign byte_length   = cur.byte_length;
  assign truncated     = cur.truncated;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      idx <= '0;
    end else if (load) begin
      rem <= load_cnt;
      idx <= '0;
    end else if (out_valid && out_ready) begin
      rem <= rem - 3'd1;
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ents <= load_res;
    end
  end

endmodule

// ===== sv/utf16_to_utf8_encoder_core.sv =====
// A unit is taken into the input register, planned combinationally and loaded into
// the result buffer, which offers its results. The buffer hands out one result
// byte per cycle while out_ready is high, up to 6 per unit. A unit with no result
// commits without waiting; any other waits in the input register until the buffer drains.
// Reset (rst, synchronous): clears string state, buffers and count-only mode, capacity to 1024.
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_core
// UTF-16 code unit stream to UTF-8 byte stream with terminator and length.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf16_to_utf8_encoder_core import u2u8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_terminator,
  output logic        run_last,
  output logic [10:0] byte_length,
  output logic        truncated
);

  logic [10:0]            capacity;
  logic                   count_only;
  logic                   unit_valid;
  logic [15:0]            unit_q;
  str_state_t             state;
  str_state_t             state_next;
  res_t [RESULTS_MAX-1:0] plan_res;
  logic [2:0]             plan_cnt;
  logic                   buf_free;
  logic                   commit;
  logic                   cfg_wr;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAPACITY_RST;
      count_only <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_CAPACITY:   capacity   <= pwdata[10:0];
        REG_COUNT_ONLY: count_only <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CAPACITY:   prdata = {21'd0, capacity};
      REG_COUNT_ONLY: prdata = {31'd0, count_only};
      default:        prdata = '0;
    endcase
  end

  // input register; a unit with no results commits without waiting for the buffer
  assign commit   = unit_valid && (plan_cnt == '0 || buf_free);
  assign in_ready = !unit_valid || commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_valid <= 1'b0;
    end else if (in_ready) begin
      unit_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      unit_q <= code_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (commit) begin
      state <= state_next;
    end
  end

  u2u8_plan u_plan (
    .unit       (unit_q),
    .state      (state),
    .capacity   (capacity),
    .count_only (count_only),
    .state_next (state_next),
    .res        (plan_res),
    .res_cnt    (plan_cnt)
  );

  u2u8_outbuf u_outbuf (
    .clk           (clk),
    .rst           (rst),
    .load          (commit && plan_cnt != '0),
    .load_res      (plan_res),
    .load_cnt      (plan_cnt),
    .free          (buf_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .is_terminator (is_terminator),
    .run_last      (run_last),
    .byte_length   (byte_length),
    .truncated     (truncated)
  );

  // a held surrogate is only kept while output is still running
  `ASSERT_ALWAYS(a_held_not_stopped, !(state.have_held && state.stopped))
  `ASSERT_IMPL(a_term_is_last, out_valid && is_terminator, run_last)
  `ASSERT_IMPL(a_len_only_on_term, out_valid && !is_terminator,
               byte_length == '0 && !truncated)
  `ASSERT_NEXT(a_term_clears, commit && unit_q == '0,
               state.bytes_written == '0 && !state.stopped && !state.have_held)

endmodule

// ===== tb/sv/utf16_to_utf8_encoder_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_core_test
// Self-checking bench for the UTF-16 to UTF-8 encoder core. Code units are
// queued by the stimulus process and fed through a valid/ready driver, and an
// encoder model predicts each output byte, terminator, length and
// truncation flag. The monitor checks every result transaction in order.
// Configuration is changed over APB between phases, with the block idle.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_core_test;
  import u2u8_pkg::*;

  localparam logic [2:0] ADDR_CAPACITY   = {REG_CAPACITY, 2'b00};
  localparam logic [2:0] ADDR_COUNT_ONLY = {REG_COUNT_ONLY, 2'b00};
  localparam int DRAIN_SLACK  = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTED = 10;

  typedef enum logic [1:0] {
    IDLE_RECV_HEAVY,
    IDLE_SEND_HEAVY,
    IDLE_OFF
  } idle_mode_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] code_unit;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        is_terminator;
  logic        run_last;
  logic [10:0] byte_length;
  logic        truncated;

  utf16_to_utf8_encoder_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .code_unit     (code_unit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .is_terminator (is_terminator),
    .run_last      (run_last),
    .byte_length   (byte_length),
    .truncated     (truncated)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  idle_mode_t  idle_mode;
  logic [15:0] pending_units[$];
  res_t        expected_bytes[$];
  int          mismatches;
  int          cycle_count;

  // encoder model: configuration and string state
  logic [10:0] cfg_capacity;
  logic        cfg_count_only;
  logic [9:0]  m_held_high;
  logic        m_have_held;
  logic [10:0] m_written;
  logic        m_stopped;
  res_t        step_res[RESULTS_MAX];
  int          step_n;

  task automatic put_result(input logic [7:0] b, input logic term,
                            input logic [10:0] len, input logic trunc);
    res_t r;
    r.out_byte      = b;
    r.is_terminator = term;
    r.run_last      = 1'b0;
    r.byte_length   = len;
    r.truncated     = trunc;
    step_res[step_n] = r;
    step_n++;
  endtask

  task automatic emit_seq(input logic [7:0] b0, input logic [7:0] b1,
                          input logic [7:0] b2, input logic [7:0] b3, input int n);
    int          total;
    int          room;
    logic [7:0]  bb[4];
    bb[0] = b0;
    bb[1] = b1;
    bb[2] = b2;
    bb[3] = b3;
    room  = (cfg_capacity > MAX_CAPACITY) ? int'(MAX_CAPACITY) : int'(cfg_capacity);
    if (m_stopped) return;
    if (cfg_count_only) begin
      total = int'(m_written) + n;
      if (total > int'(COUNT_LIMIT)) total = int'(COUNT_LIMIT);
      m_written = total[10:0];
      return;
    end
    if (int'(m_written) + n + 1 > room) begin
      m_stopped = 1'b1;
      return;
    end
    for (int i = 0; i < n; i++) put_result(bb[i], 1'b0, 11'd0, 1'b0);
    m_written = m_written + n[10:0];
  endtask

  task automatic emit_bmp(input logic [15:0] u);
    if (u <= UNIT_1B_MAX)
      emit_seq(u[7:0], 8'h00, 8'h00, 8'h00, 1);
    else if (u <= UNIT_2B_MAX)
      emit_seq(LEAD_2B | {3'b000, u[10:6]}, CONT | {2'b00, u[5:0]}, 8'h00, 8'h00, 2);
    else
      emit_seq(LEAD_3B | {4'b0000, u[15:12]}, CONT | {2'b00, u[11:6]},
               CONT | {2'b00, u[5:0]}, 8'h00, 3);
  endtask

  task automatic predict_utf8(input logic [15:0] u);
    logic [10:0] z;
    logic [9:0]  lo;
    logic        paired;
    res_t        r;
    step_n = 0;
    paired = 1'b0;
    if (m_have_held) begin
      m_have_held = 1'b0;
      if ((u & SURR_MASK) == SURR_LOW) begin
        z  = {1'b0, m_held_high} + PLANE_OFS;
        lo = u[9:0];
        emit_seq(LEAD_4B | {5'b00000, z[10:8]}, CONT | {2'b00, z[7:2]},
                 CONT | {2'b00, z[1:0], lo[9:6]}, CONT | {2'b00, lo[5:0]}, 4);
        paired = 1'b1;
      end else begin
        // lone high surrogate goes out as a plain 3-byte sequence
        emit_bmp(SURR_HIGH | {6'b000000, m_held_high});
      end
      m_held_high = '0;
    end
    if (!paired) begin
      if (u == 16'h0000) begin
        put_result(8'h00, 1'b1, m_written, m_stopped);
        m_held_high = '0;
        m_have_held = 1'b0;
        m_written   = '0;
        m_stopped   = 1'b0;
      end else if (!m_stopped) begin
        if ((u & SURR_MASK) == SURR_HIGH) begin
          m_held_high = u[9:0];
          m_have_held = 1'b1;
        end else begin
          emit_bmp(u);
        end
      end
    end
    for (int i = 0; i < step_n; i++) begin
      r = step_res[i];
      r.run_last = (i == step_n - 1);
      expected_bytes.push_back(r);
    end
  endtask

  function automatic logic send_idle();
    case (idle_mode)
      IDLE_RECV_HEAVY: return ($urandom_range(99) < 26);
      IDLE_SEND_HEAVY: return ($urandom_range(99) < 73);
      default:         return 1'b0;
    endcase
  endfunction

  function automatic logic recv_ready();
    case (idle_mode)
      IDLE_RECV_HEAVY: return ($urandom_range(99) >= 73);
      IDLE_SEND_HEAVY: return ($urandom_range(99) >= 26);
      default:         return 1'b1;
    endcase
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_utf8(code_unit);
      if (!in_valid || in_ready) begin
        if (pending_units.size() > 0 && !send_idle()) begin
          in_valid  <= 1'b1;
          code_unit <= pending_units.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("unexpected result: byte %h term %b last %b len %0d trunc %b",
                     out_byte, is_terminator, run_last, byte_length, truncated);
        end else begin
          e = expected_bytes.pop_front();
          if (out_byte !== e.out_byte || is_terminator !== e.is_terminator ||
              run_last !== e.run_last || byte_length !== e.byte_length ||
              truncated !== e.truncated) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED) begin
              $display("mismatch: exp byte %h term %b last %b len %0d trunc %b",
                       e.out_byte, e.is_terminator, e.run_last, e.byte_length,
                       e.truncated);
              $display("          got byte %h term %b last %b len %0d trunc %b",
                       out_byte, is_terminator, run_last, byte_length, truncated);
            end
          end
        end
      end
      out_ready <= recv_ready();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** utf16_to_utf8_encoder_core: FAILED **");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_CAPACITY)
      cfg_capacity = data[10:0];
    else
      cfg_count_only = data[0];
  endtask

  task automatic set_config(input logic [10:0] cap, input logic co);
    apb_write(ADDR_CAPACITY, {21'd0, cap});
    apb_write(ADDR_COUNT_ONLY, {31'd0, co});
  endtask

  // wait for every unit to go in and every expected byte to come out
  task automatic settle();
    do @(negedge clk);
    while (pending_units.size() != 0 || in_valid || expected_bytes.size() != 0);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic push_char();
    logic [9:0] hi;
    case ($urandom_range(4))
      0: pending_units.push_back(16'($urandom_range(16'h0001, 16'h007f)));
      1: pending_units.push_back(16'($urandom_range(16'h0080, 16'h07ff)));
      2: begin
        if ($urandom_range(1))
          pending_units.push_back(16'($urandom_range(16'h0800, 16'hd7ff)));
        else
          pending_units.push_back(16'($urandom_range(16'he000, 16'hffff)));
      end
      default: begin
        hi = 10'($urandom);
        pending_units.push_back(SURR_HIGH | {6'b000000, hi});
        pending_units.push_back(SURR_LOW | 16'($urandom_range(16'h03ff)));
      end
    endcase
  endtask

  task automatic push_string(input logic terminate);
    int n;
    n = $urandom_range(1, 8);
    repeat (n) push_char();
    if (terminate) pending_units.push_back(16'h0000);
  endtask

  task automatic push_noise();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(4))
        0: pending_units.push_back(16'($urandom));
        1: pending_units.push_back(SURR_HIGH | 16'($urandom_range(16'h03ff)));
        2: pending_units.push_back(SURR_LOW | 16'($urandom_range(16'h03ff)));
        3: pending_units.push_back(16'h0000);
        default: begin
          pending_units.push_back(SURR_HIGH | 16'($urandom_range(16'h03ff)));
          pending_units.push_back(SURR_HIGH | 16'($urandom_range(16'h03ff)));
        end
      endcase
    end
  endtask

  function automatic logic [10:0] pick_capacity();
    case ($urandom_range(9))
      0:       return 11'd0;
      1:       return 11'd1024;
      2:       return 11'd2047;
      3:       return 11'($urandom);
      default: return 11'($urandom_range(1, 40));
    endcase
  endfunction

  initial begin
    int start;
    clk            = 1'b0;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    code_unit      = '0;
    out_ready      = 1'b0;
    idle_mode      = IDLE_RECV_HEAVY;
    mismatches     = 0;
    cycle_count    = 0;
    cfg_capacity   = CAPACITY_RST;
    cfg_count_only = 1'b0;
    m_held_high    = '0;
    m_have_held    = 1'b0;
    m_written      = '0;
    m_stopped      = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: code point boundaries, pairs, lone surrogates
    set_config(11'd1024, 1'b0);
    pending_units = '{16'h0001, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hffff,
                      16'hd800, 16'hdc00, 16'hdbff, 16'hdfff, 16'hd800, 16'h0041,
                      16'hdc00, 16'hdbff, 16'hd801, 16'hdc01, 16'hd83d, 16'h0000};
    settle();
    // no room at all, then room for one byte plus terminator
    set_config(11'd0, 1'b0);
    pending_units = '{16'h0041, 16'h0000};
    settle();
    set_config(11'd2, 1'b0);
    pending_units = '{16'h0041, 16'h0042, 16'h0000};
    settle();
    // stopped string ignores surrogates and stays stopped after a mode change
    set_config(11'd4, 1'b0);
    pending_units = '{16'h0041, 16'h0800, 16'hd800, 16'hdc00};
    settle();
    set_config(11'd2047, 1'b1);
    pending_units = '{16'h07ff, 16'hd800, 16'hdc00, 16'h0000};
    settle();

    for (int s = 0; s < 12; s++) begin
      idle_mode = idle_mode_t'(s / 4);
      set_config(pick_capacity(), ($urandom_range(3) == 0));
      start = pending_units.size();
      while (pending_units.size() - start < 6) begin
        if ($urandom_range(9) < 7) push_string(1'b1);
        else push_noise();
      end
      // sometimes leave a string open across the next settings change
      if ($urandom_range(9) < 3) push_string(1'b0);
      settle();
    end

    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("** utf16_to_utf8_encoder_core: PASSED **");
    end else begin
      $display("** utf16_to_utf8_encoder_core: FAILED **");
    end
    $finish;
  end

endmodule
